@@ rtl/shbs_pkg.sv @@
// shared types and constants for the string hash bucket select block
package shbs_pkg;

  localparam int KEY_W      = 8;
  localparam int IDX_W      = 16;
  localparam int BC_W       = 17;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 17;

  localparam logic [12:0] DJB2_START   = 13'd5381;
  localparam int          SDBM_SHIFT_A = 6;
  localparam int          SDBM_SHIFT_B = 16;
  localparam int          DJB2_SHIFT   = 5;

  localparam logic [BC_W-1:0] BUCKETS_RESET = 17'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_HASH_MODE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 8'd1;

  localparam logic MODE_SDBM = 1'b0;
  localparam logic MODE_DJB2 = 1'b1;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/shbs_key_if.sv @@
// key byte request channel
interface shbs_key_if;
  import shbs_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_byte;

  modport source (output valid, output key_byte, input ready);
  modport sink   (input valid, input key_byte, output ready);
endinterface

@@ rtl/shbs_bucket_if.sv @@
// bucket index result channel
interface shbs_bucket_if;
  import shbs_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] bucket_index;

  modport source (output valid, output bucket_index, input ready);
  modport sink   (input valid, input bucket_index, output ready);
endinterface

@@ rtl/shbs_cfg_if.sv @@
// configuration register write channel
interface shbs_cfg_if;
  import shbs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ rtl/shbs_mod_unit.sv @@
// bit-serial restoring remainder unit: hash modulo bucket count
module shbs_mod_unit #(
  parameter int HASH_WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  shbs_pkg::div_ctl_t          ctl,
  input  logic [HASH_WIDTH-1:0]       dividend,
  input  logic [shbs_pkg::BC_W-1:0]   divisor,
  output shbs_pkg::div_stat_t         stat,
  output logic [shbs_pkg::BC_W-1:0]   remainder
);
  import shbs_pkg::*;

  localparam int CNT_W = $clog2(HASH_WIDTH);

  logic [BC_W-1:0]       rem_r,  rem_nxt;
  logic [HASH_WIDTH-1:0] dvd_r,  dvd_nxt;
  logic [BC_W-1:0]       dvs_r,  dvs_nxt;
  logic [CNT_W-1:0]      cnt_r,  cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [BC_W:0]         trial;

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[HASH_WIDTH-1]};
    if (ctl.start) begin
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(HASH_WIDTH - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // one restore-subtract step per cycle, msb first
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = BC_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[BC_W-1:0];
      end
      dvd_nxt = {dvd_r[HASH_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r;

endmodule

@@ rtl/string_hash_bucket_select.sv @@
// top level: sdbm / djb2 string hash with bucket selection
//
//   channel     dir   handshake        payload
//   in_key      in    valid / ready    key_byte      (8 bits)
//   out_bucket  out   valid / ready    bucket_index  (16 bits)
//   cfg_wr      in    valid / ready    reg_index, wdata (17 bits)
//
// a non-zero byte is folded into the accumulator register, so bytes stream at one per cycle while the block is idle
// a zero byte starts the bit-serial remainder unit, which does one step a cycle; no key byte is taken while it runs
// the result sits in an output register; non-zero bytes are taken while it waits
// a finished remainder holds the block until the output register is free
// synchronous active-low reset: mode djb2, 1024 buckets, accumulator 5381; cfg_wr is always ready
module string_hash_bucket_select #(
  parameter int              HASH_WIDTH  = 64,
  parameter longint unsigned MAX_BUCKETS = 64'd65536
) (
  input  logic         clk,
  input  logic         rst_n,
  shbs_key_if.sink     in_key,
  shbs_bucket_if.source out_bucket,
  shbs_cfg_if.sink     cfg_wr
);
  import shbs_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_HOLD} state_t;

  state_t                state_r,     state_nxt;
  logic [HASH_WIDTH-1:0] acc_r,       acc_nxt;
  logic                  mode_r,      mode_nxt;
  logic [BC_W-1:0]       bcount_r,    bcount_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]      out_idx_r,   out_idx_nxt;

  div_ctl_t              div_ctl;
  div_stat_t             div_stat;
  logic [BC_W-1:0]       div_rem;
  logic [BC_W-1:0]       eff_buckets;
  logic [HASH_WIDTH-1:0] start_val;
  logic [HASH_WIDTH-1:0] c_ext;
  logic [HASH_WIDTH-1:0] acc_upd;
  logic                  in_acc;
  logic                  out_free;

  assign in_key.ready     = (state_r == ST_IDLE);
  assign in_acc           = in_key.valid && in_key.ready;
  assign out_free         = !out_valid_r || out_bucket.ready;
  assign out_bucket.valid = out_valid_r;
  assign out_bucket.bucket_index = out_idx_r;
  assign cfg_wr.ready     = 1'b1;

  assign start_val = (mode_r == MODE_DJB2) ? HASH_WIDTH'(DJB2_START) : '0;

  // char is signed: sign-extend the byte
  assign c_ext = {{(HASH_WIDTH-KEY_W){in_key.key_byte[KEY_W-1]}}, in_key.key_byte};

  always_comb begin
    if (mode_r == MODE_DJB2) begin
      acc_upd = (acc_r << DJB2_SHIFT) + acc_r + c_ext;
    end else begin
      acc_upd = c_ext + (acc_r << SDBM_SHIFT_A) + (acc_r << SDBM_SHIFT_B) - acc_r;
    end
  end

  // zero buckets act as one, large counts saturate at MAX_BUCKETS
  always_comb begin
    if (bcount_r == '0) begin
      eff_buckets = BC_W'(1);
    end else if (64'(bcount_r) > 64'(MAX_BUCKETS)) begin
      eff_buckets = BC_W'(MAX_BUCKETS);
    end else begin
      eff_buckets = bcount_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    mode_nxt      = mode_r;
    bcount_nxt    = bcount_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    div_ctl.start = 1'b0;

    if (out_valid_r && out_bucket.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_key.key_byte == '0) begin
            div_ctl.start = 1'b1;
            acc_nxt       = start_val;
            state_nxt     = ST_DIV;
          end else begin
            acc_nxt = acc_upd;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_idx_nxt   = div_rem[IDX_W-1:0];
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = div_rem[IDX_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg_wr.valid && cfg_wr.ready) begin
      unique case (cfg_wr.reg_index)
        REG_HASH_MODE: begin
          // mode change drops any partial key
          mode_nxt = cfg_wr.wdata[0];
          acc_nxt  = (cfg_wr.wdata[0] == MODE_DJB2) ? HASH_WIDTH'(DJB2_START) : '0;
        end
        REG_BUCKET_COUNT: bcount_nxt = cfg_wr.wdata[BC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_idx_r <= out_idx_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= HASH_WIDTH'(DJB2_START);
      mode_r      <= MODE_DJB2;
      bcount_r    <= BUCKETS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      mode_r      <= mode_nxt;
      bcount_r    <= bcount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  shbs_mod_unit #(
    .HASH_WIDTH (HASH_WIDTH)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (acc_r),
    .divisor   (eff_buckets),
    .stat      (div_stat),
    .remainder (div_rem)
  );

`ifndef SYNTHESIS
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> !in_key.ready)
    else $error("key accepted while remainder unit busy");

  a_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (div_stat.busy || div_stat.done) |-> (state_r == ST_DIV))
    else $error("remainder unit running outside divide state");

  a_hold_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) |-> out_valid_r)
    else $error("holding a result while output register is free");

  a_reload_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_key.key_byte == '0) && !cfg_wr.valid) |=> (acc_r == start_val))
    else $error("accumulator not reloaded at end of key");
`endif

endmodule
